// ===== hw/rtl/lpsl_pkg.sv =====
// Shared types, codes and color tables for the loop pedal state and LED control core.
// No dependencies; imported by lpsl_flash_timer and loop_pedal_state_led_control_core.
package lpsl_pkg;

	localparam int CFG_W          = 16;
	localparam int CFG_INDEX_W    = 1;
	localparam int MAX_LAYERS_DEF = 255;
	localparam int TIMER_W_DEF    = 16;

	localparam logic [CFG_W-1:0] WHITE_LEN_RST  = 16'd120;
	localparam logic [CFG_W-1:0] EFFECT_LEN_RST = 16'd400;

	localparam logic [CFG_INDEX_W-1:0] REG_WHITE_LEN  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_LEN = 1'b1;

	localparam logic [7:0] BTN_RECORD = 8'd0;
	localparam logic [7:0] BTN_DRUMS  = 8'd1;
	localparam logic [7:0] BTN_UNDO   = 8'd2;
	localparam logic [7:0] BTN_RESET  = 8'd3;

	localparam logic signed [1:0] DRUM_NONE = 2'sb00;
	localparam logic signed [1:0] DRUM_ON   = 2'sb01;
	localparam logic signed [1:0] DRUM_OFF  = 2'sb11;

	localparam logic [1:0] CHAIN_MASK = 2'h3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// One update request for a flash timer.
	typedef struct packed {
		logic start;
		logic stop;
		logic tick;
	} flash_cmd_t;

	localparam rgb_t RGB_WHITE = '{red: 8'd255, green: 8'd255, blue: 8'd255};

	// Color of each effect chain step.
	function automatic rgb_t chain_color(input logic [1:0] idx);
		rgb_t c;
		case (idx)
			2'd0:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
			2'd1:    c = '{red: 8'd0,   green: 8'd80,  blue: 8'd255};
			2'd2:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
			default: c = '{red: 8'd255, green: 8'd140, blue: 8'd0};
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/loop_pedal_state_led_control_core.sv =====
// Loop pedal state machine with indicator LED color, one word in, one word out.
// Depends on lpsl_pkg and lpsl_flash_timer (two instances: white and effect flash).
//
// Usage:
//   Input stream s_axis: tuser = 0 marks a button press whose code is in tdata,
//   tuser = 1 marks a one-millisecond tick (tdata ignored). Every accepted word
//   produces exactly one result word on m_axis, carrying the looper state after
//   the word, layer count, drum routing, drum change event, effect chain and
//   the LED color.
//   Configuration: cfg_we writes cfg_data into register cfg_index at the clock
//   edge: index 0 is the white flash length, index 1 the effect flash length,
//   both in milliseconds. Write only while the block is idle.
//   Output: the result appears in the output register at the edge
//   after acceptance. Throughput: one word per cycle, set by the single result
//   register; while it is full, s_axis_tready follows m_axis_tready.
//   Stall: while m_axis_tvalid is high and m_axis_tready low, the result word
//   holds and s_axis_tready drops; no word is lost.
//   Reset (arst_n low): looper clear, zero layers, drums off, clean chain, both
//   flashes off, lengths back to 120 ms and 400 ms, output empty.
module loop_pedal_state_led_control_core #(
	parameter int MAX_LAYERS  = lpsl_pkg::MAX_LAYERS_DEF,
	parameter int TIMER_WIDTH = lpsl_pkg::TIMER_W_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [lpsl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lpsl_pkg::CFG_W-1:0]       cfg_data,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // [7:0] button
	input  logic                             s_axis_tuser,  // [0] mode (1 = tick)
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] accepted, [3:1] loop_state, [11:4] layers, [12] drums_on,
	// [14:13] drum_change, [16:15] effect_chain, [24:17] led_red,
	// [32:25] led_green, [40:33] led_blue, [47:41] zero
	output logic [47:0]                      m_axis_tdata
);
	import lpsl_pkg::*;

	localparam int LAYER_W  = $clog2(MAX_LAYERS + 1);
	localparam int LAYER_XW = (LAYER_W > 8) ? LAYER_W : 8;
	localparam logic [LAYER_W-1:0] LAYER_MAX = LAYER_W'(MAX_LAYERS);

	typedef enum logic [2:0] {
		ST_CLEAR       = 3'd0,
		ST_RECORDING   = 3'd1,
		ST_PLAYING     = 3'd2,
		ST_OVERDUBBING = 3'd3,
		ST_PAUSED      = 3'd4
	} loop_st_t;

	// Color of each looper state; anything else shows the clear color.
	function automatic rgb_t state_color(input loop_st_t code);
		rgb_t c;
		case (code) inside
			ST_RECORDING, ST_OVERDUBBING: c = '{red: 8'd255, green: 8'd0, blue: 8'd0};
			ST_PLAYING: c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
			ST_PAUSED:  c = '{red: 8'd128, green: 8'd0,   blue: 8'd180};
			default:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd180};
		endcase
		return c;
	endfunction

	// configuration
	logic [CFG_W-1:0] white_len_q;
	logic [CFG_W-1:0] effect_len_q;

	// looper state
	loop_st_t          st_q, st_d;
	logic [LAYER_W-1:0] layer_q, layer_d;
	logic              drum_q, drum_d;
	logic [1:0]        chain_q, chain_d;

	// handshake and per-word decode
	logic              take;
	logic              press;
	logic              accepted_d;
	logic signed [1:0] change_d;
	flash_cmd_t        white_cmd, effect_cmd;
	logic              white_act_d, effect_act_d;
	rgb_t              led_d;
	logic [LAYER_XW-1:0] layer_ext;

	// result register
	logic              out_valid_q;
	logic [47:0]       out_data_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign press         = !s_axis_tuser;

	// Hold configuration; the user must write only while idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_len_q  <= WHITE_LEN_RST;
			effect_len_q <= EFFECT_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WHITE_LEN:  white_len_q  <= cfg_data;
				REG_EFFECT_LEN: effect_len_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// Next looper state for the word at the input.
	always_comb begin
		st_d       = st_q;
		layer_d    = layer_q;
		drum_d     = drum_q;
		chain_d    = chain_q;
		accepted_d = 1'b0;
		change_d   = DRUM_NONE;
		white_cmd  = '0;
		effect_cmd = '0;
		white_cmd.tick  = take && !press;
		effect_cmd.tick = take && !press;
		if (press) begin
			// every press restarts the white flash, known button or not, but drums stop it
			white_cmd.start = take;
			accepted_d      = (s_axis_tdata <= BTN_RESET);
			unique case (s_axis_tdata)
				BTN_RECORD: begin
					unique case (st_q)
						ST_CLEAR:     st_d = ST_RECORDING;
						ST_RECORDING: begin
							// first loop closed: one layer, drums drop out
							st_d    = ST_PLAYING;
							layer_d = LAYER_W'(1);
							if (drum_q) begin
								drum_d   = 1'b0;
								change_d = DRUM_OFF;
							end
						end
						ST_PLAYING:   st_d = ST_OVERDUBBING;
						ST_OVERDUBBING: begin
							st_d = ST_PLAYING;
							if (layer_q < LAYER_MAX)
								layer_d = layer_q + 1'b1;
						end
						default:      st_d = ST_OVERDUBBING;
					endcase
				end
				BTN_DRUMS: begin
					// toggle drums, advance the chain, swap to the effect flash
					drum_d           = !drum_q;
					change_d         = drum_q ? DRUM_OFF : DRUM_ON;
					chain_d          = (chain_q + 2'd1) & CHAIN_MASK;
					white_cmd.stop   = take;
					effect_cmd.start = take;
				end
				BTN_UNDO: begin
					if (layer_q != '0) begin
						layer_d = layer_q - 1'b1;
						if (layer_q == LAYER_W'(1))
							st_d = ST_CLEAR;
						else if (st_q == ST_OVERDUBBING)
							st_d = ST_PLAYING;
					end
				end
				BTN_RESET: begin
					st_d    = ST_CLEAR;
					layer_d = '0;
					chain_d = '0;
					if (drum_q) begin
						drum_d   = 1'b0;
						change_d = DRUM_OFF;
					end
				end
				default: ;
			endcase
		end
	end

	lpsl_flash_timer #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_white_flash (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (white_cmd),
		.length      (white_len_q),
		.active_next (white_act_d)
	);

	lpsl_flash_timer #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_effect_flash (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (effect_cmd),
		.length      (effect_len_q),
		.active_next (effect_act_d)
	);

	// Effect flash wins over white flash, which wins over the state color.
	always_comb begin
		if (effect_act_d)
			led_d = chain_color(chain_d);
		else if (white_act_d)
			led_d = RGB_WHITE;
		else
			led_d = state_color(st_d);
	end

	assign layer_ext = LAYER_XW'(layer_d);

	// Advance state on an accepted word, load the result register, and
	// drop valid once the receiver has taken the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			layer_q     <= '0;
			drum_q      <= 1'b0;
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				st_q        <= st_d;
				layer_q     <= layer_d;
				drum_q      <= drum_d;
				chain_q     <= chain_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= {7'd0, led_d.blue, led_d.green, led_d.red, chain_d,
			               change_d, drum_d, layer_ext[7:0], st_d, accepted_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/lpsl_flash_timer.sv =====
// One LED flash timer: active flag and saturating elapsed count, aged by ticks.
// Depends on lpsl_pkg (flash_cmd_t, CFG_W).
module lpsl_flash_timer #(
	parameter int TIMER_WIDTH = lpsl_pkg::TIMER_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lpsl_pkg::flash_cmd_t     cmd,
	input  logic [lpsl_pkg::CFG_W-1:0] length,
	output logic                     active_next
);
	import lpsl_pkg::*;

	localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam logic [TIMER_WIDTH-1:0] ELAPSED_MAX = {TIMER_WIDTH{1'b1}};

	logic                   active_q;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic [TIMER_WIDTH-1:0] elapsed_d;
	logic [TIMER_WIDTH-1:0] aged;

	assign aged = (elapsed_q != ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;

	always_comb begin
		active_next = active_q;
		elapsed_d   = elapsed_q;
		if (cmd.stop) begin
			active_next = 1'b0;
			elapsed_d   = '0;
		end else if (cmd.start) begin
			active_next = 1'b1;
			elapsed_d   = '0;
		end else if (cmd.tick && active_q) begin
			elapsed_d = aged;
			if (CMP_W'(aged) > CMP_W'(length))
				active_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			elapsed_q <= '0;
		end else begin
			active_q  <= active_next;
			elapsed_q <= elapsed_d;
		end
	end

endmodule
